@@ design/dsk_pkg.sv @@
// Shared constants, types and the angle table for the scattering kinematics block.
// Used by dsk_cordic, dsk_div_pipe and dis_scattering_kinematics_top.
package dsk_pkg;

  localparam int unsigned ENERGY_W = 24;
  localparam int unsigned ANGLE_W  = 24;
  localparam int unsigned SQ_W     = 31;

  localparam logic [ENERGY_W-1:0] BEAM_RESET = 24'd720896;
  localparam logic [ANGLE_W-1:0]  ANGLE_MAX  = 24'd11796480;

  // proton mass and derived constants, all Q.16 or Q.32, in GeV or GeV^2
  localparam logic [31:0] MASS_SQ     = 32'd3781143081;
  localparam logic [17:0] TWO_MASS    = 18'd122982;
  localparam logic [16:0] TWO_MASS2   = 17'd115392;
  localparam logic [17:0] FOUR_MASS2  = 18'd230784;

  localparam int          CORDIC_GAIN  = 652032874;
  localparam int unsigned CORDIC_STEPS = 22;

  localparam logic [16:0] ETA_ONE = 17'd65536;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NU_NONPOS = 2'd1,
    STATUS_X_SAT     = 2'd2
  } status_e;

  typedef struct packed {
    logic [24:0] nu;
    logic [31:0] p;
  } cdc_pay_t;

  typedef struct packed {
    logic [34:0] q2;
    logic [40:0] d;
    logic        nupos;
    logic        sat;
    logic [24:0] nu;
    logic [35:0] w2;
  } eta_pay_t;

  typedef struct packed {
    logic [24:0] nu;
    logic [35:0] w2;
    logic [16:0] eta;
    logic        nupos;
    logic        sat;
    logic [33:0] q2;
  } xdiv_pay_t;

  // atan(2^-i) in degrees, Q.17
  function automatic logic [22:0] atan_deg(input int unsigned idx);
    case (idx)
      0:       return 23'd5898240;
      1:       return 23'd3481935;
      2:       return 23'd1839759;
      3:       return 23'd933890;
      4:       return 23'd468757;
      5:       return 23'd234607;
      6:       return 23'd117332;
      7:       return 23'd58670;
      8:       return 23'd29335;
      9:       return 23'd14668;
      10:      return 23'd7334;
      11:      return 23'd3667;
      12:      return 23'd1833;
      13:      return 23'd917;
      14:      return 23'd458;
      15:      return 23'd229;
      16:      return 23'd115;
      17:      return 23'd57;
      18:      return 23'd29;
      19:      return 23'd14;
      20:      return 23'd7;
      21:      return 23'd4;
      default: return 23'd0;
    endcase
  endfunction

endpackage

@@ design/dsk_cordic.sv @@
// Pipelined rotation CORDIC giving sin^2 and cos^2 of half the scattering angle.
// One rotation per stage, then a squaring stage and a clamp stage; uses dsk_pkg.
module dsk_cordic #(
  parameter int unsigned PAY_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [dsk_pkg::ANGLE_W-1:0] angle_i,
  input  logic [PAY_W-1:0]            pay_i,
  output logic                        valid_o,
  output logic [dsk_pkg::SQ_W-1:0]    sin_sq_o,
  output logic [dsk_pkg::SQ_W-1:0]    cos_sq_o,
  output logic [PAY_W-1:0]            pay_o
);
  import dsk_pkg::*;

  localparam int unsigned XY_W = 32;
  localparam int unsigned Z_W  = 26;

  logic signed [XY_W-1:0] x_q [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_q [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_q [CORDIC_STEPS];
  logic                   v_q [CORDIC_STEPS];
  logic [PAY_W-1:0]       p_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
    logic signed [XY_W-1:0] x_in, y_in, dx, dy;
    logic signed [Z_W-1:0]  z_in, at;
    logic                   v_in;
    logic [PAY_W-1:0]       p_in;

    if (i == 0) begin : g_first
      assign x_in = XY_W'(CORDIC_GAIN);
      assign y_in = '0;
      assign z_in = $signed({2'b00, angle_i});
      assign v_in = valid_i;
      assign p_in = pay_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign v_in = v_q[i-1];
      assign p_in = p_q[i-1];
    end

    // arithmetic shifts floor toward minus infinity
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = $signed({3'b000, atan_deg(i)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[i] <= p_in;
        if (z_in >= 0) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - at;
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + at;
        end
      end
    end
  end

  logic [XY_W-1:0]   ax, ay;
  logic [63:0]       sqx_q, sqy_q;
  logic              vsq_q, vout_q;
  logic [PAY_W-1:0]  psq_q, pout_q;
  logic [SQ_W-1:0]   s_q, c_q;

  assign ax = x_q[CORDIC_STEPS-1][XY_W-1] ? XY_W'(-x_q[CORDIC_STEPS-1])
                                          : XY_W'(x_q[CORDIC_STEPS-1]);
  assign ay = y_q[CORDIC_STEPS-1][XY_W-1] ? XY_W'(-y_q[CORDIC_STEPS-1])
                                          : XY_W'(y_q[CORDIC_STEPS-1]);

  function automatic logic [SQ_W-1:0] clamp_q30(input logic [63:0] sq);
    if (sq[63:30] > 34'h40000000) begin
      return 31'h40000000;
    end
    return sq[60:30];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsq_q  <= 1'b0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      vsq_q  <= v_q[CORDIC_STEPS-1];
      vout_q <= vsq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q  <= ax * ax;
      sqy_q  <= ay * ay;
      psq_q  <= p_q[CORDIC_STEPS-1];
      c_q    <= clamp_q30(sqx_q);
      s_q    <= clamp_q30(sqy_q);
      pout_q <= psq_q;
    end
  end

  assign valid_o  = vout_q;
  assign sin_sq_o = s_q;
  assign cos_sq_o = c_q;
  assign pay_o    = pout_q;

endmodule

@@ design/dsk_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Needs num_i below den_i shifted left by the quotient width; uses dsk_pkg.
module dsk_div_pipe #(
  parameter int unsigned NUM_W = 8,
  parameter int unsigned DEN_W = 8,
  parameter int unsigned QUO_W = 8,
  parameter int unsigned PAY_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [PAY_W-1:0] pay_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [PAY_W-1:0] pay_o
);
  import dsk_pkg::*;

  localparam int unsigned REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [REM_W-1:0] r_q [QUO_W];
  logic [DEN_W-1:0] d_q [QUO_W];
  logic [QUO_W-1:0] q_q [QUO_W];
  logic             v_q [QUO_W];
  logic [PAY_W-1:0] p_q [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_st
    logic [REM_W-1:0] r_in, dsh;
    logic [DEN_W-1:0] d_in;
    logic [QUO_W-1:0] q_in;
    logic             v_in, ge;
    logic [PAY_W-1:0] p_in;

    if (i == 0) begin : g_first
      assign r_in = REM_W'(num_i);
      assign d_in = den_i;
      assign q_in = '0;
      assign v_in = valid_i;
      assign p_in = pay_i;
    end else begin : g_next
      assign r_in = r_q[i-1];
      assign d_in = d_q[i-1];
      assign q_in = q_q[i-1];
      assign v_in = v_q[i-1];
      assign p_in = p_q[i-1];
    end

    // divisor aligned to the quotient bit this stage decides
    assign dsh = REM_W'(d_in) << (QUO_W - 1 - i);
    assign ge  = (r_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= ge ? (r_in - dsh) : r_in;
        d_q[i] <= d_in;
        q_q[i] <= {q_in[QUO_W-2:0], ge};
        p_q[i] <= p_in;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = q_q[QUO_W-1];
  assign pay_o   = p_q[QUO_W-1];

endmodule

@@ design/dis_scattering_kinematics_top.sv @@
// Deep inelastic scattering kinematics: nu, Q2, Bjorken x, W2 and eta per event.
// Top level; instantiates dsk_cordic and two dsk_div_pipe, uses dsk_pkg.
//
// Usage:
//   Events enter on the s_axis channel (scattered energy, scattering angle) and
//   one result per event leaves on the m_axis channel, in order. tuser carries
//   the status code (ok, nu not positive, x saturated).
//   The beam energy register is loaded through cfg_wr_en_i / cfg_wr_data_i and
//   should only change while no event is in flight.
//   Throughput is one event per cycle while s_axis_tready_o is high. The result
//   reaches m_axis through 81 register stages: 2 input stages, 24 in the
//   CORDIC (22 rotations, square, clamp), 5 multiply/add stages, 17 in the eta
//   divider, 32 in the x divider and the output register.
//   The whole pipeline advances on one enable. When the receiver stalls, the
//   output register holds its result and one more result lands in a skid
//   register; only then does s_axis_tready_o drop and the pipeline freeze, so no
//   result is lost or repeated.
//   Reset clears all valid bits and restores the beam energy to 11 GeV.
module dis_scattering_kinematics_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_en_i,
  input  logic [23:0]   cfg_wr_data_i,   // beam_energy
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [47:0]   s_axis_tdata_i,  // scattered_energy, scatter_angle
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // energy_transfer, momentum_transfer_sq, bjorken_x, invariant_mass_sq, polarization
  output logic [143:0]  m_axis_tdata_o,
  output logic [1:0]    m_axis_tuser_o   // status
);
  import dsk_pkg::*;

  logic en;
  logic [ENERGY_W-1:0] beam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q <= BEAM_RESET;
    end else if (cfg_wr_en_i) begin
      beam_q <= cfg_wr_data_i;
    end
  end

  // stages 1..2: capture, clamp angle, then nu and E0*E'
  logic                v1_q, v2_q;
  logic [ENERGY_W-1:0] e0_1_q, ep_1_q;
  logic [ANGLE_W-1:0]  th_1_q, th_2_q, th_in;
  logic [24:0]         nu_2_q;
  logic [47:0]         prod_2_q;

  assign th_in = (s_axis_tdata_i[47:24] > ANGLE_MAX) ? ANGLE_MAX : s_axis_tdata_i[47:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_1_q   <= beam_q;
      ep_1_q   <= s_axis_tdata_i[23:0];
      th_1_q   <= th_in;
      nu_2_q   <= {1'b0, e0_1_q} - {1'b0, ep_1_q};
      prod_2_q <= e0_1_q * ep_1_q;
      th_2_q   <= th_1_q;
    end
  end

  cdc_pay_t        cpay_in, cpay_out;
  logic            cv;
  logic [SQ_W-1:0] s_sq, c_sq;
  logic [47:0]     prod_rnd;

  assign prod_rnd    = prod_2_q + 48'd32768;
  assign cpay_in.nu  = nu_2_q;
  assign cpay_in.p   = prod_rnd[47:16];

  dsk_cordic #(
    .PAY_W($bits(cdc_pay_t))
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v2_q),
    .angle_i  (th_2_q),
    .pay_i    (cpay_in),
    .valid_o  (cv),
    .sin_sq_o (s_sq),
    .cos_sq_o (c_sq),
    .pay_o    (cpay_out)
  );

  // stages 3..7: Q2, W2 and the eta operands
  logic               v3_q, v4_q, v5_q, v6_q, v7_q;
  logic [62:0]        q2prod_3_q, q2_rnd;
  logic [24:0]        s24_3_q, c24_3_q, s24_4_q, c24_4_q, nu_3_q, nu_4_q;
  logic [24:0]        nu_5_q, nu_6_q, nu_7_q;
  logic [31:0]        s_rnd, c_rnd;
  logic [34:0]        q2_4_q, q2_5_q, q2_6_q, q2_7_q;
  logic signed [42:0] mnu2_4_q, mnu2_d;
  logic               nupos_4_q, nupos_5_q, nupos_6_q, nupos_7_q;
  logic               sat_5_q, sat_6_q, sat_7_q;
  logic [41:0]        num_5_q, num_6_q;
  logic [42:0]        t1_5_q;
  logic [59:0]        t2_5_q, den_6_q, den_7_q;
  logic [60:0]        n_7_q;
  logic [40:0]        d_5_q, d_6_q, d_7_q;
  logic [35:0]        w2_5_q, w2_6_q, w2_7_q;
  logic signed [53:0] w2_full;

  assign s_rnd   = {1'b0, s_sq} + 32'd32;
  assign c_rnd   = {1'b0, c_sq} + 32'd32;
  assign q2_rnd  = q2prod_3_q + 63'd134217728;
  assign mnu2_d  = $signed({1'b0, TWO_MASS}) * $signed(nu_3_q);
  // W2 in Q.32, rounded half up to Q.16 by the floor shift
  assign w2_full = $signed(54'(MASS_SQ)) + 54'(mnu2_4_q)
                 - $signed({3'b000, q2_4_q, 16'h0000}) + 54'sd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v3_q <= cv;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q2prod_3_q <= cpay_out.p * s_sq;
      s24_3_q    <= s_rnd[30:6];
      c24_3_q    <= c_rnd[30:6];
      nu_3_q     <= cpay_out.nu;

      q2_4_q     <= q2_rnd[62:28];
      mnu2_4_q   <= mnu2_d;
      nupos_4_q  <= ~nu_3_q[24] && (nu_3_q != '0);
      s24_4_q    <= s24_3_q;
      c24_4_q    <= c24_3_q;
      nu_4_q     <= nu_3_q;

      num_5_q    <= TWO_MASS2 * c24_4_q;
      t1_5_q     <= FOUR_MASS2 * s24_4_q;
      t2_5_q     <= q2_4_q * s24_4_q;
      w2_5_q     <= w2_full[51:16];
      d_5_q      <= mnu2_4_q[40:0];
      sat_5_q    <= nupos_4_q && (41'(q2_4_q) >= mnu2_4_q[40:0]);
      nupos_5_q  <= nupos_4_q;
      q2_5_q     <= q2_4_q;
      nu_5_q     <= nu_4_q;

      den_6_q    <= 60'(num_5_q) + 60'(t1_5_q) + t2_5_q;
      num_6_q    <= num_5_q;
      w2_6_q     <= w2_5_q;
      d_6_q      <= d_5_q;
      sat_6_q    <= sat_5_q;
      nupos_6_q  <= nupos_5_q;
      q2_6_q     <= q2_5_q;
      nu_6_q     <= nu_5_q;

      n_7_q      <= {3'b000, num_6_q, 16'h0000} + 61'(den_6_q >> 1);
      den_7_q    <= den_6_q;
      w2_7_q     <= w2_6_q;
      d_7_q      <= d_6_q;
      sat_7_q    <= sat_6_q;
      nupos_7_q  <= nupos_6_q;
      q2_7_q     <= q2_6_q;
      nu_7_q     <= nu_6_q;
    end
  end

  // eta = (num * 2^16 + den / 2) / den
  eta_pay_t    epay_in, epay_out;
  logic        ev;
  logic [16:0] eta_quo, eta_clamped;

  assign epay_in.q2    = q2_7_q;
  assign epay_in.d     = d_7_q;
  assign epay_in.nupos = nupos_7_q;
  assign epay_in.sat   = sat_7_q;
  assign epay_in.nu    = nu_7_q;
  assign epay_in.w2    = w2_7_q;

  dsk_div_pipe #(
    .NUM_W(61),
    .DEN_W(60),
    .QUO_W(17),
    .PAY_W($bits(eta_pay_t))
  ) u_div_eta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (n_7_q),
    .den_i   (den_7_q),
    .pay_i   (epay_in),
    .valid_o (ev),
    .quo_o   (eta_quo),
    .pay_o   (epay_out)
  );

  assign eta_clamped = (eta_quo > ETA_ONE) ? ETA_ONE : eta_quo;

  // x = Q2 * 2^32 / (2 M nu), only meaningful when nu > 0 and not saturated
  xdiv_pay_t   xpay_in, xpay_out;
  logic        xv;
  logic [31:0] x_quo, x_final;
  status_e     status;

  assign xpay_in.nu    = epay_out.nu;
  assign xpay_in.w2    = epay_out.w2;
  assign xpay_in.eta   = eta_clamped;
  assign xpay_in.nupos = epay_out.nupos;
  assign xpay_in.sat   = epay_out.sat;
  assign xpay_in.q2    = epay_out.q2[33:0];

  dsk_div_pipe #(
    .NUM_W(67),
    .DEN_W(41),
    .QUO_W(32),
    .PAY_W($bits(xdiv_pay_t))
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ev),
    .num_i   ({epay_out.q2, 32'h0000_0000}),
    .den_i   (epay_out.d),
    .pay_i   (xpay_in),
    .valid_o (xv),
    .quo_o   (x_quo),
    .pay_o   (xpay_out)
  );

  always_comb begin
    if (!xpay_out.nupos) begin
      x_final = '0;
      status  = STATUS_NU_NONPOS;
    end else if (xpay_out.sat) begin
      x_final = '1;
      status  = STATUS_X_SAT;
    end else begin
      x_final = x_quo;
      status  = STATUS_OK;
    end
  end

  // output register plus skid register
  logic [143:0] res_data, out_data_q, skid_data_q;
  logic [1:0]   res_user, out_user_q, skid_user_q;
  logic         out_v_q, skid_v_q;

  assign res_data = {xpay_out.eta, xpay_out.w2, x_final, xpay_out.q2, xpay_out.nu};
  assign res_user = status;
  assign en       = ~skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready_i) begin
      out_v_q  <= skid_v_q | xv;
      skid_v_q <= 1'b0;
    end else if (en && xv) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready_i) begin
      out_data_q <= skid_v_q ? skid_data_q : res_data;
      out_user_q <= skid_v_q ? skid_user_q : res_user;
    end else if (en && xv) begin
      skid_data_q <= res_data;
      skid_user_q <= res_user;
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

@@ verif/dis_scattering_kinematics_top_tb.sv @@
// Testbench for dis_scattering_kinematics_top: random and directed events, with a
// bit-exact kinematics predictor and an in-order scoreboard. Depends on dsk_pkg.
module dis_scattering_kinematics_top_tb;
  import dsk_pkg::*;

  localparam longint MASS_Q16 = 61491;
  localparam longint ANGLE_SAT = 11796480;
  localparam longint ROT_GAIN = 652032874;
  localparam int LATENCY = 81;
  localparam longint ATAN_Q17 [22] = '{
    5898240, 3481935, 1839759, 933890, 468757, 234607, 117332, 58670,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4};

  typedef struct {
    logic [24:0] nu;
    logic [33:0] q2;
    logic [31:0] xbj;
    logic [35:0] w2;
    logic [16:0] eta;
    status_e     status;
  } kin_t;

  class kin_scoreboard;
    kin_t             pending[$];
    logic [23:0]      beam;
    int               errors;

    function new();
      beam = BEAM_RESET;
      errors = 0;
    endfunction

    function longint unsigned sq_clamp(longint v);
      longint unsigned a, sq;
      a = (v < 0) ? -v : v;
      sq = (a * a) >> 30;
      return (sq > (64'd1 << 30)) ? (64'd1 << 30) : sq;
    endfunction

    function kin_t kinematics(logic [23:0] ep_in, logic [23:0] th_in);
      kin_t k;
      longint nu, cx, cy, cz, dx, dy, w2a, w2r;
      longint unsigned e0, ep, th, p, s2, c2, q2, d, q1, r, qa, qb;
      longint unsigned m2, s24, c24, num, den, eta;
      e0 = beam;
      ep = ep_in;
      th = (th_in > ANGLE_SAT) ? ANGLE_SAT : th_in;
      nu = longint'(e0) - longint'(ep);
      p = (e0 * ep + 32768) >> 16;
      // rotate by half the angle: the Q.16 angle read as Q.17
      cx = ROT_GAIN;
      cy = 0;
      cz = th;
      for (int i = 0; i < 22; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cz >= 0) begin
          cx -= dx; cy += dy; cz -= ATAN_Q17[i];
        end else begin
          cx += dx; cy -= dy; cz += ATAN_Q17[i];
        end
      end
      s2 = sq_clamp(cy);
      c2 = sq_clamp(cx);
      q2 = (p * s2 + (64'd1 << 27)) >> 28;
      k.status = STATUS_OK;
      if (nu <= 0) begin
        k.xbj = '0;
        k.status = STATUS_NU_NONPOS;
      end else begin
        d = 2 * MASS_Q16 * nu;
        q1 = q2 / d;
        r = q2 % d;
        if (q1 != 0) begin
          k.xbj = '1;
          k.status = STATUS_X_SAT;
        end else begin
          qa = (r << 16) / d;
          r = (r << 16) % d;
          qb = (r << 16) / d;
          k.xbj = (qa << 16) + qb;
        end
      end
      w2a = MASS_Q16 * MASS_Q16 + 2 * MASS_Q16 * nu - longint'(q2 << 16);
      w2r = longint'(($unsigned(w2a + (64'sd1 <<< 52)) + 32768) >> 16)
            - (64'sd1 <<< 36);
      m2 = (MASS_Q16 * MASS_Q16 + 32768) >> 16;
      s24 = (s2 + 32) >> 6;
      c24 = (c2 + 32) >> 6;
      num = 2 * m2 * c24;
      den = num + 4 * m2 * s24 + q2 * s24;
      eta = (den == 0) ? 65536 : ((num << 16) + den / 2) / den;
      if (eta > 65536) eta = 65536;
      k.nu = nu[24:0];
      k.q2 = q2[33:0];
      k.w2 = w2r[35:0];
      k.eta = eta[16:0];
      return k;
    endfunction

    function void note_event(logic [23:0] ep, logic [23:0] th);
      pending.push_back(kinematics(ep, th));
    endfunction

    function void check_result(logic [143:0] data, logic [1:0] user);
      kin_t k;
      if (pending.size() == 0) begin
        $error("result with no event pending: data %h user %0d", data, user);
        errors++;
        return;
      end
      k = pending.pop_front();
      if (data[24:0] !== k.nu) begin
        $error("energy_transfer exp %h got %h", k.nu, data[24:0]); errors++;
      end
      if (data[58:25] !== k.q2) begin
        $error("momentum_transfer_sq exp %h got %h", k.q2, data[58:25]); errors++;
      end
      if (data[90:59] !== k.xbj) begin
        $error("bjorken_x exp %h got %h", k.xbj, data[90:59]); errors++;
      end
      if (data[126:91] !== k.w2) begin
        $error("invariant_mass_sq exp %h got %h", k.w2, data[126:91]); errors++;
      end
      if (data[143:127] !== k.eta) begin
        $error("polarization exp %h got %h", k.eta, data[143:127]); errors++;
      end
      if (user !== k.status) begin
        $error("status exp %0d got %0d", k.status, user); errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_wr_en_i = 1'b0;
  logic [23:0]   cfg_wr_data_i = '0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [47:0]   s_axis_tdata_i = '0;  // scattered_energy, scatter_angle
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [143:0]  m_axis_tdata_o;       // nu, q2, x, w2, eta
  logic [1:0]    m_axis_tuser_o;       // status

  kin_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  dis_scattering_kinematics_top DUT (.*);

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_event(logic [23:0] ep, logic [23:0] th);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {th, ep};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_event(ep, th);
    @(negedge clk_i);
  endtask

  // drain the pipeline, then load a new beam energy
  task automatic set_beam(logic [23:0] e0);
    s_axis_tvalid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    cfg_wr_en_i = 1'b1;
    cfg_wr_data_i = e0;
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
    sb.beam = e0;
  endtask

  task automatic random_events(int n);
    logic [23:0] ep;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: ep = 24'($urandom);
        1: ep = 24'(sb.beam - $urandom_range(4095) + 2048);  // small nu, x may saturate
        default: ep = 24'($urandom_range(sb.beam));
      endcase
      send_event(ep, ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(ANGLE_SAT)));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_event(24'd0, 24'd0);
    send_event(24'hFFFFFF, 24'(ANGLE_SAT));
    send_event(24'hFFFFFF, 24'hFFFFFF);
    send_event(BEAM_RESET, 24'd2949120);
    send_event(BEAM_RESET - 24'd1, 24'(ANGLE_SAT));
    send_event(BEAM_RESET - 24'd1, 24'd65536);
    send_event(24'd327680, 24'd1966080);
    send_event(24'd1, 24'd1);
    send_event(24'd655360, 24'd11796481);
    set_beam(24'd0);
    send_event(24'd0, 24'd5898240);
    send_event(24'd100, 24'd1000);
    set_beam(24'hFFFFFF);
    send_event(24'd0, 24'(ANGLE_SAT));
    send_event(24'hFFFFFE, 24'd11000000);
    send_event(24'h800000, 24'd3000000);
    send_idle_pct = 33;
    recv_idle_pct = 65;
    set_beam(BEAM_RESET);
    random_events(100);
    set_beam(24'($urandom));
    random_events(100);
    send_idle_pct = 65;
    recv_idle_pct = 33;
    set_beam(24'($urandom_range(2000000)));
    random_events(100);
    set_beam(24'hFFFFFF);
    random_events(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_beam(24'($urandom));
    random_events(100);
    set_beam(24'd0);
    random_events(30);
    set_beam(24'($urandom));
    random_events(70);
    s_axis_tvalid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 20) @(negedge clk_i);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("FAIL");
    $finish;
  end

endmodule
